### hw/rtl/html_entity_escape_codec_defines.svh
// assertion macros for the entity codec
// every macro samples on i_clk and is held off while i_rst_n is low
`ifndef HTML_ENTITY_ESCAPE_CODEC_DEFINES_SVH
`define HTML_ENTITY_ESCAPE_CODEC_DEFINES_SVH

// same-cycle implication
`define HEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("entity codec check failed");

// next-cycle implication
`define HEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("entity codec check failed");

`endif

### hw/rtl/hec_pkg.sv
package hec_pkg;

    localparam int MaxRes = 5;
    localparam int CntW   = $clog2(MaxRes + 1);

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChGt   = 8'h3E;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChL    = 8'h6C;
    localparam logic [7:0] ChT    = 8'h74;
    localparam logic [7:0] ChG    = 8'h67;
    localparam logic [7:0] ChA    = 8'h61;
    localparam logic [7:0] ChM    = 8'h6D;
    localparam logic [7:0] ChP    = 8'h70;

    // partial entity match held in decode mode
    typedef enum logic [3:0] {
        P_IDLE = 4'd0,
        P_AMP  = 4'd1,
        P_L    = 4'd2,
        P_LT   = 4'd3,
        P_G    = 4'd4,
        P_GT   = 4'd5,
        P_A    = 4'd6,
        P_AM   = 4'd7,
        P_AMPP = 4'd8
    } t_prog;

    // all result bytes of one request
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [CntW-1:0]        cnt;
        t_prog                  next_st;
    } t_res;

endpackage

### hw/rtl/html_entity_escape_codec.sv
// flow: an accepted request waits in the input register until the result buffer is free,
// then loads into the buffer, which puts its first result byte on the output
// throughput: one request per cycle while each yields a single byte and i_out_ready is
// high; a request that expands to more bytes holds the result buffer until the last is taken (up to 5)
// reset: synchronous, active low; selects encode mode, clears match state and both stages
module html_entity_escape_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_string_end
);
    import hec_pkg::*;

`include "html_entity_escape_codec_defines.svh"

    // input register: takes a request whenever it is empty, so the input
    // side keeps moving while the result buffer still waits downstream
    logic       r_in_vld, n_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // mode register and held partial entity
    logic  r_mode;
    t_prog r_prog, n_prog;

    t_res res;
    logic buf_free;
    logic accept;
    logic process;

    assign accept     = i_in_valid && o_in_ready;
    assign process    = r_in_vld && buf_free;
    assign o_in_ready = !r_in_vld || buf_free;

    // single-pass conversion of the held request
    hec_expand u_expand (
        .i_decode_mode (r_mode),
        .i_prog        (r_prog),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .o_res         (res)
    );

    // result buffer, drains one byte per cycle while i_out_ready is high
    hec_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (process),
        .i_res      (res),
        .i_res_last (r_in_last),
        .o_free     (buf_free),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_out_last),
        .o_str_end  (o_string_end)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (process) begin
            n_in_vld = 1'b0;
        end
    end

    // a mode write drops any partial match
    always_comb begin
        n_prog = r_prog;
        if (i_cfg_wr_en) begin
            n_prog = P_IDLE;
        end else if (process) begin
            n_prog = res.next_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= 1'b0;
            r_prog   <= P_IDLE;
        end else begin
            r_in_vld <= n_in_vld;
            r_prog   <= n_prog;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
        end
    end

    // encode mode always yields at least one byte
    `HEC_ASSERT_NOW(a_enc_nonempty, process && !r_mode, res.cnt != '0)
    // end of string yields output and leaves no match pending
    `HEC_ASSERT_NOW(a_last_flush, process && r_in_last, res.cnt != '0 && res.next_st == P_IDLE)
    // encode mode leaves the match state alone
    `HEC_ASSERT_NEXT(a_enc_keeps_prog, process && !r_mode && !i_cfg_wr_en, r_prog == $past(r_prog))

endmodule

### hw/rtl/hec_expand.sv
module hec_expand (
    input  logic           i_decode_mode,
    input  hec_pkg::t_prog i_prog,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output hec_pkg::t_res  o_res
);
    import hec_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_held;

    function automatic t_held held_of(input t_prog s);
        t_held h;
        h.b = '0;
        h.n = 3'd0;
        case (s)
            P_AMP:  begin h.b[0] = ChAmp; h.n = 3'd1; end
            P_L:    begin h.b[0] = ChAmp; h.b[1] = ChL; h.n = 3'd2; end
            P_LT:   begin h.b[0] = ChAmp; h.b[1] = ChL; h.b[2] = ChT; h.n = 3'd3; end
            P_G:    begin h.b[0] = ChAmp; h.b[1] = ChG; h.n = 3'd2; end
            P_GT:   begin h.b[0] = ChAmp; h.b[1] = ChG; h.b[2] = ChT; h.n = 3'd3; end
            P_A:    begin h.b[0] = ChAmp; h.b[1] = ChA; h.n = 3'd2; end
            P_AM:   begin h.b[0] = ChAmp; h.b[1] = ChA; h.b[2] = ChM; h.n = 3'd3; end
            P_AMPP: begin
                h.b[0] = ChAmp; h.b[1] = ChA; h.b[2] = ChM; h.b[3] = ChP; h.n = 3'd4;
            end
            default: ;
        endcase
        return h;
    endfunction

    always_comb begin : expand
        t_held           hd;
        t_prog           st;
        t_prog           nx;
        logic            miss;
        logic            has_done;
        logic [7:0]      done_ch;
        logic [CntW-1:0] n;

        o_res         = '0;
        o_res.next_st = i_prog;
        hd            = '0;
        st            = i_prog;
        nx            = P_IDLE;
        miss          = 1'b1;
        has_done      = 1'b0;
        done_ch       = '0;
        n             = '0;

        if (!i_decode_mode) begin
            case (i_byte)
                ChAmp: begin
                    o_res.bytes[0] = ChAmp; o_res.bytes[1] = ChA; o_res.bytes[2] = ChM;
                    o_res.bytes[3] = ChP;   o_res.bytes[4] = ChSemi;
                    n = CntW'(5);
                end
                ChLt: begin
                    o_res.bytes[0] = ChAmp; o_res.bytes[1] = ChL; o_res.bytes[2] = ChT;
                    o_res.bytes[3] = ChSemi;
                    n = CntW'(4);
                end
                ChGt: begin
                    o_res.bytes[0] = ChAmp; o_res.bytes[1] = ChG; o_res.bytes[2] = ChT;
                    o_res.bytes[3] = ChSemi;
                    n = CntW'(4);
                end
                default: begin
                    o_res.bytes[0] = i_byte;
                    n = CntW'(1);
                end
            endcase
        end else begin
            // match step
            case (st)
                P_AMP: begin
                    if (i_byte == ChL) begin
                        nx = P_L; miss = 1'b0;
                    end else if (i_byte == ChG) begin
                        nx = P_G; miss = 1'b0;
                    end else if (i_byte == ChA) begin
                        nx = P_A; miss = 1'b0;
                    end
                end
                P_L:  if (i_byte == ChT) begin nx = P_LT; miss = 1'b0; end
                P_G:  if (i_byte == ChT) begin nx = P_GT; miss = 1'b0; end
                P_A:  if (i_byte == ChM) begin nx = P_AM; miss = 1'b0; end
                P_AM: if (i_byte == ChP) begin nx = P_AMPP; miss = 1'b0; end
                P_LT: if (i_byte == ChSemi) begin
                    miss = 1'b0; has_done = 1'b1; done_ch = ChLt;
                end
                P_GT: if (i_byte == ChSemi) begin
                    miss = 1'b0; has_done = 1'b1; done_ch = ChGt;
                end
                P_AMPP: if (i_byte == ChSemi) begin
                    miss = 1'b0; has_done = 1'b1; done_ch = ChAmp;
                end
                default: ;
            endcase

            if (st != P_IDLE && !miss) begin
                if (has_done) begin
                    o_res.bytes[n] = done_ch;
                    n = n + CntW'(1);
                end
                st = nx;
            end else begin
                // mismatch: release held bytes, then treat byte as fresh
                if (st != P_IDLE) begin
                    hd = held_of(st);
                    for (int i = 0; i < 4; i++) begin
                        if (i < int'(hd.n)) begin
                            o_res.bytes[n] = hd.b[i];
                            n = n + CntW'(1);
                        end
                    end
                end
                if (i_byte == ChAmp) begin
                    st = P_AMP;
                end else begin
                    o_res.bytes[n] = i_byte;
                    n = n + CntW'(1);
                    st = P_IDLE;
                end
            end

            // end of string flushes what is still held
            if (i_last) begin
                hd = held_of(st);
                for (int i = 0; i < 4; i++) begin
                    if (i < int'(hd.n) && n < CntW'(MaxRes)) begin
                        o_res.bytes[n] = hd.b[i];
                        n = n + CntW'(1);
                    end
                end
                st = P_IDLE;
            end
            o_res.next_st = st;
        end
        o_res.cnt = n;
    end

endmodule

### hw/rtl/hec_out_buf.sv
module hec_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  hec_pkg::t_res i_res,
    input  logic          i_res_last,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_str_end
);
    import hec_pkg::*;

    logic [MaxRes-1:0][7:0] r_bytes, n_bytes;
    logic [CntW-1:0]        r_left, n_left;
    logic                   r_str, n_str;
    logic                   take;

    assign take      = o_valid && i_ready;
    assign o_valid   = (r_left != '0);
    assign o_byte    = r_bytes[0];
    assign o_last    = (r_left == CntW'(1));
    assign o_str_end = o_last && r_str;
    assign o_free    = (r_left == '0) || (o_last && i_ready);

    always_comb begin
        n_bytes = r_bytes;
        n_left  = r_left;
        n_str   = r_str;
        if (i_load) begin
            n_bytes = i_res.bytes;
            n_left  = i_res.cnt;
            n_str   = i_res_last;
        end else if (take) begin
            for (int i = 0; i < MaxRes - 1; i++) begin
                n_bytes[i] = r_bytes[i+1];
            end
            n_left = r_left - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_str   <= n_str;
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule
